### rtl/assert_macros.svh
// assertion helpers shared by cbe_pack and cbe_serialize
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge outside reset
`define CBE_ASSERT(lbl, clk_i, rstn_i, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) prop) \
    else $error("%m: check failed");

// condition must never be seen outside reset
`define CBE_ASSERT_NEVER(lbl, clk_i, rstn_i, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define CBE_ASSERT(lbl, clk_i, rstn_i, prop)
`define CBE_ASSERT_NEVER(lbl, clk_i, rstn_i, expr)

`endif

`endif

### rtl/cbe_pkg.sv
`timescale 1ns / 1ps

package cbe_pkg;

  localparam int FUNC_W  = 3;
  localparam int MAJOR_W = 3;
  localparam int VALUE_W = 64;
  localparam int BYTE_W  = 8;
  localparam int INFO_W  = 5;
  localparam int MAX_BYTES = 9;
  localparam int BUF_W   = BYTE_W * MAX_BYTES;
  localparam int SH_W    = BUF_W - BYTE_W;
  localparam int CNT_W   = 4;

  // command selector codes
  localparam logic [FUNC_W-1:0] FUNC_HEAD    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SIMPLE  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_FLOAT32 = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_FLOAT64 = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_BREAK   = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_RAW     = 3'd5;

  // additional info codes
  localparam logic [INFO_W-1:0] AI_INLINE_LIMIT = 5'd24;
  localparam logic [INFO_W-1:0] AI_ONE_BYTE     = 5'd24;
  localparam logic [INFO_W-1:0] AI_TWO_BYTES    = 5'd25;
  localparam logic [INFO_W-1:0] AI_FOUR_BYTES   = 5'd26;
  localparam logic [INFO_W-1:0] AI_EIGHT_BYTES  = 5'd27;
  localparam logic [INFO_W-1:0] AI_INDEFINITE   = 5'd31;

  localparam logic [MAJOR_W-1:0] MAJOR_SPECIAL = 3'd7;

  // length class of a head argument
  typedef enum logic [2:0] {
    SZ_INLINE,
    SZ_ONE,
    SZ_TWO,
    SZ_FOUR,
    SZ_EIGHT
  } size_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [MAJOR_W-1:0] major;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    cmd_t  cmd;
    size_t size;
  } cls_t;

  // encoded bytes, first byte in the top bits
  typedef struct packed {
    logic [BUF_W-1:0] bytes;
    logic [CNT_W-1:0] count;
  } frame_t;

  function automatic logic [BYTE_W-1:0] initial_byte(logic [MAJOR_W-1:0] major,
                                                     logic [INFO_W-1:0] info);
    return {major, info};
  endfunction

endpackage

### rtl/cbe_classify.sv
`timescale 1ns / 1ps

module cbe_classify (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  cbe_pkg::cmd_t in_cmd,
  output logic          cls_valid,
  input  logic          cls_ready,
  output cbe_pkg::cls_t cls
);
  import cbe_pkg::*;

  logic s1_valid_r;
  cls_t s1_r;
  cls_t s1_nxt;
  logic take;

  assign in_ready = !s1_valid_r || cls_ready;
  assign take     = in_valid && in_ready;

  // pick the shortest argument length for a head
  always_comb begin
    s1_nxt.cmd = in_cmd;
    if (in_cmd.value < VALUE_W'(AI_INLINE_LIMIT)) begin
      s1_nxt.size = SZ_INLINE;
    end else if (in_cmd.value[VALUE_W-1:8] == '0) begin
      s1_nxt.size = SZ_ONE;
    end else if (in_cmd.value[VALUE_W-1:16] == '0) begin
      s1_nxt.size = SZ_TWO;
    end else if (in_cmd.value[VALUE_W-1:32] == '0) begin
      s1_nxt.size = SZ_FOUR;
    end else begin
      s1_nxt.size = SZ_EIGHT;
    end
  end

  // stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (take) begin
      s1_r <= s1_nxt;
    end
  end

  assign cls_valid = s1_valid_r;
  assign cls       = s1_r;

endmodule

### rtl/cbe_pack.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cbe_pack (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cls_valid,
  output logic            cls_ready,
  input  cbe_pkg::cls_t   cls,
  output logic            frame_valid,
  input  logic            frame_ready,
  output cbe_pkg::frame_t frame
);
  import cbe_pkg::*;

  logic        s2_valid_r;
  frame_t      s2_r;
  frame_t      s2_nxt;
  logic [BYTE_W-1:0] head_ib;
  logic [BYTE_W-1:0] sv;

  assign cls_ready = !s2_valid_r || frame_ready;
  assign sv        = cls.cmd.value[BYTE_W-1:0];

  // initial byte of a head
  always_comb begin
    case (cls.size)
      SZ_INLINE: head_ib = initial_byte(cls.cmd.major, cls.cmd.value[INFO_W-1:0]);
      SZ_ONE:    head_ib = initial_byte(cls.cmd.major, AI_ONE_BYTE);
      SZ_TWO:    head_ib = initial_byte(cls.cmd.major, AI_TWO_BYTES);
      SZ_FOUR:   head_ib = initial_byte(cls.cmd.major, AI_FOUR_BYTES);
      default:   head_ib = initial_byte(cls.cmd.major, AI_EIGHT_BYTES);
    endcase
  end

  // lay out the encoded bytes, first byte on top
  always_comb begin
    s2_nxt.bytes = '0;
    s2_nxt.count = '0;
    unique case (cls.cmd.func)
      FUNC_HEAD: begin
        case (cls.size)
          SZ_INLINE: begin
            s2_nxt.bytes = {head_ib, 64'd0};
            s2_nxt.count = CNT_W'(1);
          end
          SZ_ONE: begin
            s2_nxt.bytes = {head_ib, cls.cmd.value[7:0], 56'd0};
            s2_nxt.count = CNT_W'(2);
          end
          SZ_TWO: begin
            s2_nxt.bytes = {head_ib, cls.cmd.value[15:0], 48'd0};
            s2_nxt.count = CNT_W'(3);
          end
          SZ_FOUR: begin
            s2_nxt.bytes = {head_ib, cls.cmd.value[31:0], 32'd0};
            s2_nxt.count = CNT_W'(5);
          end
          default: begin
            s2_nxt.bytes = {head_ib, cls.cmd.value};
            s2_nxt.count = CNT_W'(9);
          end
        endcase
      end
      FUNC_SIMPLE: begin
        if (sv < BYTE_W'(AI_INLINE_LIMIT)) begin
          s2_nxt.bytes = {initial_byte(MAJOR_SPECIAL, sv[INFO_W-1:0]), 64'd0};
          s2_nxt.count = CNT_W'(1);
        end else begin
          s2_nxt.bytes = {initial_byte(MAJOR_SPECIAL, AI_ONE_BYTE), sv, 56'd0};
          s2_nxt.count = CNT_W'(2);
        end
      end
      FUNC_FLOAT32: begin
        s2_nxt.bytes = {initial_byte(MAJOR_SPECIAL, AI_FOUR_BYTES),
                        cls.cmd.value[31:0], 32'd0};
        s2_nxt.count = CNT_W'(5);
      end
      FUNC_FLOAT64: begin
        s2_nxt.bytes = {initial_byte(MAJOR_SPECIAL, AI_EIGHT_BYTES), cls.cmd.value};
        s2_nxt.count = CNT_W'(9);
      end
      FUNC_BREAK: begin
        s2_nxt.bytes = {initial_byte(MAJOR_SPECIAL, AI_INDEFINITE), 64'd0};
        s2_nxt.count = CNT_W'(1);
      end
      FUNC_RAW: begin
        s2_nxt.bytes = {sv, 64'd0};
        s2_nxt.count = CNT_W'(1);
      end
      default: begin
        s2_nxt.bytes = '0;
        s2_nxt.count = '0;
      end
    endcase
  end

  // unused selectors produce nothing and are dropped here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (cls_ready) begin
      s2_valid_r <= cls_valid && (s2_nxt.count != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cls_valid && cls_ready) begin
      s2_r <= s2_nxt;
    end
  end

  assign frame_valid = s2_valid_r;
  assign frame       = s2_r;

  `CBE_ASSERT(a_frame_not_empty, clk, rst_n, s2_valid_r |-> (s2_r.count != '0))
  `CBE_ASSERT_NEVER(a_frame_too_long, clk, rst_n, s2_valid_r && (s2_r.count > CNT_W'(MAX_BYTES)))
  `CBE_ASSERT(a_hold, clk, rst_n, (s2_valid_r && !frame_ready) |=> (s2_valid_r && $stable(s2_r)))

endmodule

### rtl/cbe_serialize.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cbe_serialize (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       frame_valid,
  output logic                       frame_ready,
  input  cbe_pkg::frame_t            frame,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [cbe_pkg::BYTE_W-1:0] out_tdata,
  output logic                       out_tlast
);
  import cbe_pkg::*;

  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic [SH_W-1:0]   sh_r, sh_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic              out_free;

  assign out_free = !out_valid_r || out_tready;

  // shift out pending bytes, then load the next frame
  always_comb begin
    out_valid_nxt = out_valid_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    sh_nxt        = sh_r;
    left_nxt      = left_r;
    frame_ready   = 1'b0;
    if (out_free) begin
      if (left_r != '0) begin
        byte_nxt      = sh_r[SH_W-1 -: BYTE_W];
        last_nxt      = (left_r == CNT_W'(1));
        sh_nxt        = {sh_r[SH_W-BYTE_W-1:0], BYTE_W'(0)};
        left_nxt      = left_r - CNT_W'(1);
        out_valid_nxt = 1'b1;
      end else begin
        frame_ready = 1'b1;
        if (frame_valid) begin
          byte_nxt      = frame.bytes[BUF_W-1 -: BYTE_W];
          last_nxt      = (frame.count == CNT_W'(1));
          sh_nxt        = frame.bytes[SH_W-1:0];
          left_nxt      = frame.count - CNT_W'(1);
          out_valid_nxt = 1'b1;
        end else begin
          out_valid_nxt = 1'b0;
        end
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      left_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      left_r      <= left_nxt;
    end
  end

  // byte payload
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
    sh_r   <= sh_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = byte_r;
  assign out_tlast  = last_r;

  `CBE_ASSERT_NEVER(a_left_range, clk, rst_n, left_r > CNT_W'(MAX_BYTES - 1))
  `CBE_ASSERT(a_pending_shown, clk, rst_n, (left_r != '0) |-> out_valid_r)
  `CBE_ASSERT(a_last_ends_run, clk, rst_n, (out_valid_r && last_r) |-> (left_r == '0))

endmodule

### rtl/cbor_head_encoder.sv
`timescale 1ns / 1ps
// CBOR data item head encoder
// input channel: one command per request; in_tuser selects the command
//   (head, simple value, float32, float64, break, raw byte), in_tdata carries
//   the major type and the 64-bit argument
// output channel: the encoded bytes, most significant first, one byte per
//   request; out_tlast marks the final byte of each command
// unused selector codes produce no output bytes at all
// the first byte of a command passes the classify register, the layout register
//   and the output byte register before it is presented; a stall on the
//   output can hold it in any of them
// throughput: one output byte per cycle while out_tready does not stall; a
//   command has 1 to 9 bytes, so single-byte commands stream at one per cycle
//   and a full 64-bit head has nine bytes
// the three stages are classify, byte layout and the byte shifter
// reset clears all stage valids and the shifter count; nothing is in flight
// a stall on out_tready holds the current byte and backs up stage by stage
//   to in_tready without losing or repeating any byte
module cbor_head_encoder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  // major_type [2:0], value [66:3], zero fill [71:67]
  input  logic [71:0]                in_tdata,
  // func [2:0]
  input  logic [cbe_pkg::FUNC_W-1:0] in_tuser,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // out_byte [7:0]
  output logic [cbe_pkg::BYTE_W-1:0] out_tdata,
  output logic                       out_tlast
);
  import cbe_pkg::*;

  cmd_t   in_cmd;
  logic   cls_valid;
  logic   cls_ready;
  cls_t   cls;
  logic   frame_valid;
  logic   frame_ready;
  frame_t frame;

  // unpack the request
  assign in_cmd.func  = in_tuser;
  assign in_cmd.major = in_tdata[MAJOR_W-1:0];
  assign in_cmd.value = in_tdata[MAJOR_W +: VALUE_W];

  cbe_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_cmd),
    .cls_valid (cls_valid),
    .cls_ready (cls_ready),
    .cls       (cls)
  );

  cbe_pack u_pack (
    .clk         (clk),
    .rst_n       (rst_n),
    .cls_valid   (cls_valid),
    .cls_ready   (cls_ready),
    .cls         (cls),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame)
  );

  cbe_serialize u_serialize (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_valid (frame_valid),
    .frame_ready (frame_ready),
    .frame       (frame),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import cbe_pkg::*;

  // selector codes the block leaves without output
  localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
  localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

  localparam int RANDOM_CMDS    = 288;
  localparam int QUIET_TAIL     = 40;
  localparam int STALL_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 20;
  localparam int REPORT_LIMIT   = 10;

  typedef struct {
    logic [FUNC_W-1:0]  func;
    logic [MAJOR_W-1:0] major;
    logic [VALUE_W-1:0] value;
    bit                 drain_first;
  } cbor_cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } cbor_byte_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [71:0]       in_tdata = '0;
  logic [FUNC_W-1:0] in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [BYTE_W-1:0] out_tdata;
  logic              out_tlast;

  cbor_cmd_t  pending_cmds[$];
  cbor_byte_t encoded_bytes[$];

  logic in_took = 1'b0;
  logic quiet = 1'b0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   stall_cycles = 0;
  int   mismatches = 0;
  int   bytes_checked = 0;
  int   cmds_by_func[8];

  cbor_head_encoder uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // expected byte sequence for one command, most significant byte first
  task automatic encode_cbor_cmd(input logic [FUNC_W-1:0] func,
                                 input logic [MAJOR_W-1:0] major,
                                 input logic [VALUE_W-1:0] value);
    logic [BYTE_W-1:0] seq[$];
    logic [INFO_W-1:0] info;
    logic [BYTE_W-1:0] low_byte;
    cbor_byte_t        beat;
    int                arg_bytes;
    arg_bytes = 0;
    low_byte = value[7:0];
    case (func)
      FUNC_HEAD: begin
        if (value < AI_INLINE_LIMIT) begin
          info = value[INFO_W-1:0];
        end else if (value < 64'h100) begin
          info = AI_ONE_BYTE;
          arg_bytes = 1;
        end else if (value < 64'h1_0000) begin
          info = AI_TWO_BYTES;
          arg_bytes = 2;
        end else if (value < 64'h1_0000_0000) begin
          info = AI_FOUR_BYTES;
          arg_bytes = 4;
        end else begin
          info = AI_EIGHT_BYTES;
          arg_bytes = 8;
        end
        seq.push_back({major, info});
      end
      FUNC_SIMPLE: begin
        if (low_byte < AI_INLINE_LIMIT) begin
          seq.push_back({MAJOR_SPECIAL, low_byte[INFO_W-1:0]});
        end else begin
          seq.push_back({MAJOR_SPECIAL, AI_ONE_BYTE});
          seq.push_back(low_byte);
        end
      end
      FUNC_FLOAT32: begin
        seq.push_back({MAJOR_SPECIAL, AI_FOUR_BYTES});
        arg_bytes = 4;
      end
      FUNC_FLOAT64: begin
        seq.push_back({MAJOR_SPECIAL, AI_EIGHT_BYTES});
        arg_bytes = 8;
      end
      FUNC_BREAK: seq.push_back({MAJOR_SPECIAL, AI_INDEFINITE});
      FUNC_RAW: seq.push_back(low_byte);
      default: ;
    endcase
    for (int i = arg_bytes; i > 0; i--) begin
      seq.push_back(value[(i-1)*8 +: 8]);
    end
    foreach (seq[k]) begin
      beat.data = seq[k];
      beat.last = (k == seq.size() - 1);
      encoded_bytes.push_back(beat);
    end
  endtask

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
  endtask

  task automatic queue_cmd(input logic [FUNC_W-1:0] func, input logic [MAJOR_W-1:0] major,
                           input logic [VALUE_W-1:0] value, input bit drain_first);
    cbor_cmd_t c;
    c.func = func;
    c.major = major;
    c.value = value;
    c.drain_first = drain_first;
    pending_cmds.push_back(c);
  endtask

  // request driver, changes on the falling edge
  always @(negedge clk) begin
    cbor_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_took) begin
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_cmds.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (pending_cmds[0].drain_first && encoded_bytes.size() != 0) begin
        in_tvalid <= 1'b0;
      end else begin
        c = pending_cmds.pop_front();
        in_tdata <= {5'd0, c.value, c.major};
        in_tuser <= c.func;
        in_tvalid <= 1'b1;
        if (!quiet && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(1, 14);
        end
      end
    end
    quiet <= (pending_cmds.size() < QUIET_TAIL);
  end

  // output backpressure in bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(1, 14);
      end
    end
  end

  // sample both channels on the rising edge
  always @(posedge clk) begin
    cbor_byte_t want;
    logic in_fire;
    logic out_fire;
    in_fire = in_tvalid && in_tready;
    out_fire = out_tvalid && out_tready;
    in_took <= in_fire;

    // predict bytes for each accepted request
    if (in_fire) begin
      encode_cbor_cmd(in_tuser, in_tdata[2:0], in_tdata[66:3]);
      cmds_by_func[in_tuser]++;
    end

    // compare each byte with the oldest prediction
    if (out_fire) begin
      if (encoded_bytes.size() == 0) begin
        note_mismatch($sformatf("unexpected byte %02h last %0b", out_tdata, out_tlast));
      end else begin
        want = encoded_bytes.pop_front();
        bytes_checked++;
        if (out_tdata !== want.data || out_tlast !== want.last) begin
          note_mismatch($sformatf("expected byte %02h last %0b, got %02h last %0b",
                                  want.data, want.last, out_tdata, out_tlast));
        end
      end
    end

    // watchdog on traffic
    if (in_fire || out_fire) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("no traffic for %0d cycles, %0d bytes still expected",
               STALL_LIMIT, encoded_bytes.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus and end of run
  initial begin
    logic [FUNC_W-1:0]  func;
    logic [VALUE_W-1:0] value;
    int                 pick;

    // directed: head argument boundaries on every major type
    queue_cmd(FUNC_HEAD, 3'd0, 64'd0, 1'b0);
    queue_cmd(FUNC_HEAD, 3'd1, 64'd23, 1'b0);
    queue_cmd(FUNC_HEAD, 3'd2, 64'd24, 1'b0);
    queue_cmd(FUNC_HEAD, 3'd3, 64'd255, 1'b0);
    queue_cmd(FUNC_HEAD, 3'd4, 64'd256, 1'b0);
    queue_cmd(FUNC_HEAD, 3'd5, 64'hFFFF, 1'b0);
    queue_cmd(FUNC_HEAD, 3'd6, 64'h1_0000, 1'b0);
    queue_cmd(FUNC_HEAD, 3'd7, 64'hFFFF_FFFF, 1'b0);
    queue_cmd(FUNC_HEAD, 3'd0, 64'h1_0000_0000, 1'b0);
    queue_cmd(FUNC_HEAD, 3'd7, '1, 1'b0);
    // simple values around the inline limit, and one with junk above the low byte
    queue_cmd(FUNC_SIMPLE, 3'd0, 64'd0, 1'b0);
    queue_cmd(FUNC_SIMPLE, 3'd3, 64'd23, 1'b0);
    queue_cmd(FUNC_SIMPLE, 3'd5, 64'd24, 1'b0);
    queue_cmd(FUNC_SIMPLE, 3'd7, 64'd255, 1'b0);
    queue_cmd(FUNC_SIMPLE, 3'd2, 64'hA5A5_5A5A_F0F0_0F14, 1'b0);
    // floats, float32 with upper half set that must be dropped
    queue_cmd(FUNC_FLOAT32, 3'd1, 64'hDEAD_BEEF_3F80_0000, 1'b0);
    queue_cmd(FUNC_FLOAT64, 3'd6, 64'h8000_0000_0000_0001, 1'b0);
    // break and raw with the major type and high bits ignored
    queue_cmd(FUNC_BREAK, 3'd3, '1, 1'b0);
    queue_cmd(FUNC_RAW, 3'd7, 64'hFFFF_FFFF_FFFF_FF00, 1'b0);
    queue_cmd(FUNC_RAW, 3'd0, 64'h0000_0000_0000_00FF, 1'b0);
    // unused selectors give nothing
    queue_cmd(FUNC_SPARE_A, 3'd2, 64'h1234_5678_9ABC_DEF0, 1'b0);
    queue_cmd(FUNC_SPARE_B, 3'd5, '1, 1'b0);

    // random commands, argument sizes spread over all head lengths
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        func = $urandom_range(0, 1) ? FUNC_SPARE_A : FUNC_SPARE_B;
      end else begin
        func = FUNC_W'($urandom_range(0, 5));
      end
      value = {$urandom, $urandom};
      if (func == FUNC_HEAD && $urandom_range(0, 3) != 0) begin
        value = value >> $urandom_range(0, 63);
      end
      if ((func == FUNC_SIMPLE || func == FUNC_RAW) && $urandom_range(0, 2) == 0) begin
        value[7:0] = BYTE_W'($urandom_range(0, 23));
      end
      queue_cmd(func, MAJOR_W'($urandom_range(0, 7)), value,
                (n == 0 || n == 100 || n == 200));
    end

    // hold reset, then release it on a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait until every request is taken and every byte has come back
    while (pending_cmds.size() != 0 || in_tvalid || encoded_bytes.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("commands: %0d head, %0d simple, %0d float32, %0d float64, %0d break, %0d raw",
             cmds_by_func[FUNC_HEAD], cmds_by_func[FUNC_SIMPLE], cmds_by_func[FUNC_FLOAT32],
             cmds_by_func[FUNC_FLOAT64], cmds_by_func[FUNC_BREAK], cmds_by_func[FUNC_RAW]);
    $display("%0d unused selectors, %0d bytes checked, %0d mismatches",
             cmds_by_func[FUNC_SPARE_A] + cmds_by_func[FUNC_SPARE_B], bytes_checked,
             mismatches);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
